@@ design/assert_macros.svh @@
// assertion macros shared by the line editor rtl
// no dependencies; simulation builds see the checks, synthesis sees empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define ULNED_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ULNED_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ULNED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ULNED_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ULNED_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ULNED_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/ulned_pkg.sv @@
// shared types and codes of the utf-8 line editor
// no dependencies
`default_nettype none
package ulned_pkg;

    // width of cursor, length and counters
    localparam int CW = 7;

    // result kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_LINE   = 3'd1;
    localparam logic [2:0] KIND_EMPTY  = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;
    localparam logic [2:0] KIND_EOF    = 3'd4;

    // key codes
    localparam logic [7:0] KEY_HOME  = 8'd1;
    localparam logic [7:0] KEY_CANC  = 8'd3;
    localparam logic [7:0] KEY_DEL   = 8'd4;
    localparam logic [7:0] KEY_END   = 8'd5;
    localparam logic [7:0] KEY_BS    = 8'd8;
    localparam logic [7:0] KEY_LF    = 8'd10;
    localparam logic [7:0] KEY_KEND  = 8'd11;
    localparam logic [7:0] KEY_CR    = 8'd13;
    localparam logic [7:0] KEY_KSTA  = 8'd21;
    localparam logic [7:0] KEY_KWORD = 8'd23;
    localparam logic [7:0] KEY_ESC   = 8'd27;
    localparam logic [7:0] KEY_SPACE = 8'd32;
    localparam logic [7:0] KEY_RUB   = 8'd127;
    localparam logic [7:0] KEY_LBRK  = 8'h5B;
    localparam logic [7:0] KEY_C     = 8'h43;
    localparam logic [7:0] KEY_D     = 8'h44;
    localparam logic [7:0] KEY_H     = 8'h48;
    localparam logic [7:0] KEY_F     = 8'h46;
    localparam logic [7:0] KEY_3     = 8'h33;
    localparam logic [7:0] KEY_TILDE = 8'h7E;

    // utf-8 continuation test
    localparam logic [7:0] UTF_MASK = 8'hC0;
    localparam logic [7:0] UTF_CONT = 8'h80;

    // cell operation broadcast along the row
    typedef enum logic [1:0] {
        CM_HOLD = 2'd0,
        CM_INS  = 2'd1,
        CM_SHL  = 2'd2
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode      mode;
        logic [CW-1:0]   pos;
        logic [7:0]      data;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ design/ulned_cell.sv @@
// one byte cell of the line store row
// depends on ulned_pkg
`default_nettype none
module ulned_cell #(
    parameter int IDX = 0
) (
    input  wire                  i_clk,
    input  ulned_pkg::t_cell_ctl i_ctl,
    input  wire  [7:0]           i_left,
    input  wire  [7:0]           i_right,
    output logic [7:0]           o_data,
    output logic                 o_cont,
    output logic                 o_space
);
    import ulned_pkg::*;

    logic [7:0] r_data;
    logic [7:0] n_data;
    logic       w_above;
    logic       w_at;

    assign w_above = 7'(IDX) >  i_ctl.pos;
    assign w_at    = 7'(IDX) == i_ctl.pos;

    // insert shifts right above the cursor, erase shifts left from the start point
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.mode)
            CM_INS: begin
                if (w_at) n_data = i_ctl.data;
                else if (w_above) n_data = i_left;
            end
            CM_SHL: begin
                if (w_at || w_above) n_data = i_right;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // local flags for scans
    assign o_data  = r_data;
    assign o_cont  = (r_data & UTF_MASK) == UTF_CONT;
    assign o_space = r_data == KEY_SPACE;
endmodule
`default_nettype wire

@@ design/utf8_line_editor_top.sv @@
// a status result goes from the S_OUT state into the output register; scans and erases
// come before it; inserts, jumps and kill to end go straight to S_OUT; deletes and word kills
// scan then shift the cell row one place per cycle, kill to start shifts without a scan;
// a line is sent one byte per cycle while the output is not stalled; a new key is taken
// once the last result of the previous one has been loaded into the output register
// reset: synchronous active low, clears cursor, length, escape phase and handshakes
// the store cells are not cleared; only bytes below the length are ever read
`default_nettype none
`include "assert_macros.svh"
module utf8_line_editor_top #(
    parameter int LINE_CAPACITY = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [7:0] i_key_byte,
    input  wire        i_input_closed,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_line_byte,
    output logic [6:0] o_cursor_now,
    output logic [6:0] o_length_now,
    output logic       o_overflow,
    output logic       o_last
);
    import ulned_pkg::*;

    localparam int IW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [CW-1:0] CAP = CW'(LINE_CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FWD   = 8'b0000_0010,
        S_BWD   = 8'b0000_0100,
        S_WSP   = 8'b0000_1000,
        S_WWD   = 8'b0001_0000,
        S_ERASE = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    typedef enum logic [4:0] {
        E_IDLE    = 5'b00001,
        E_FIRST   = 5'b00010,
        E_BRACKET = 5'b00100,
        E_SKIP    = 5'b01000,
        E_TILDE   = 5'b10000
    } t_esc;

    t_state        r_state, n_state;
    t_esc          r_esc, n_esc;
    logic [CW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_p, n_p;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_from, n_from;
    logic          r_erase, n_erase;
    logic [2:0]    r_kind, n_kind;
    logic          r_ovf, n_ovf;

    logic          r_ov;
    logic [2:0]    r_okind;
    logic [7:0]    r_obyte;
    logic [CW-1:0] r_ocur, r_olen;
    logic          r_oovf, r_olast;

    logic          w_acc;
    logic          w_free;
    logic          w_load;
    logic [2:0]    w_lkind;
    logic [7:0]    w_lbyte;
    logic          w_llast;
    logic          w_lovf;
    t_cell_ctl     w_ctl;

    logic [7:0]              w_data [LINE_CAPACITY];
    logic [LINE_CAPACITY-1:0] w_cont;
    logic [LINE_CAPACITY-1:0] w_space;
    logic [IW-1:0]           w_pi;
    logic [IW-1:0]           w_pmi;
    logic [CW-1:0]           w_pm1;

    // cell row
    for (genvar g = 0; g < LINE_CAPACITY; g++) begin : g_cell
        logic [7:0] w_l, w_r;
        if (g == 0) begin : g_l0
            assign w_l = 8'd0;
        end else begin : g_ln
            assign w_l = w_data[g-1];
        end
        if (g == LINE_CAPACITY-1) begin : g_rl
            assign w_r = 8'd0;
        end else begin : g_rn
            assign w_r = w_data[g+1];
        end
        ulned_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_l),
            .i_right (w_r),
            .o_data  (w_data[g]),
            .o_cont  (w_cont[g]),
            .o_space (w_space[g])
        );
    end

    assign o_in_stall = r_state != S_IDLE;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_free     = !r_ov || !i_out_stall;
    assign w_pm1      = r_p - CW'(1);
    assign w_pi       = r_p[IW-1:0];
    assign w_pmi      = w_pm1[IW-1:0];

    // control sequencer
    always_comb begin
        n_state = r_state;
        n_esc   = r_esc;
        n_cur   = r_cur;
        n_len   = r_len;
        n_p     = r_p;
        n_cnt   = r_cnt;
        n_from  = r_from;
        n_erase = r_erase;
        n_kind  = r_kind;
        n_ovf   = r_ovf;
        w_ctl   = '{mode: CM_HOLD, pos: r_cur, data: i_key_byte};
        w_load  = 1'b0;
        w_lkind = r_kind;
        w_lbyte = 8'd0;
        w_llast = 1'b1;
        w_lovf  = r_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_kind  = KIND_STATUS;
                    n_ovf   = 1'b0;
                    n_state = S_OUT;
                    if (i_input_closed) begin
                        n_cur = '0;
                        n_len = '0;
                        n_esc = E_IDLE;
                        if (r_len != '0) begin
                            n_cnt   = r_len;
                            n_state = S_EMIT;
                        end else begin
                            n_kind = KIND_EOF;
                        end
                    end else if (r_esc == E_FIRST) begin
                        n_esc = (i_key_byte == KEY_LBRK) ? E_BRACKET : E_SKIP;
                    end else if (r_esc == E_BRACKET) begin
                        n_esc = E_IDLE;
                        priority if (i_key_byte == KEY_C) begin
                            if (r_cur < r_len) begin
                                n_p     = r_cur + CW'(1);
                                n_erase = 1'b0;
                                n_state = S_FWD;
                            end
                        end else if (i_key_byte == KEY_D) begin
                            if (r_cur != '0) begin
                                n_p     = r_cur - CW'(1);
                                n_erase = 1'b0;
                                n_state = S_BWD;
                            end
                        end else if (i_key_byte == KEY_H) begin
                            n_cur = '0;
                        end else if (i_key_byte == KEY_F) begin
                            n_cur = r_len;
                        end else if (i_key_byte == KEY_3) begin
                            n_esc = E_TILDE;
                        end else begin
                            n_esc = E_IDLE;
                        end
                    end else if (r_esc == E_SKIP || r_esc == E_TILDE) begin
                        n_esc = E_IDLE;
                        if (r_esc == E_TILDE && i_key_byte == KEY_TILDE
                                && r_cur < r_len) begin
                            n_p     = r_cur + CW'(1);
                            n_erase = 1'b1;
                            n_state = S_FWD;
                        end
                    end else begin
                        priority if (i_key_byte == KEY_CR || i_key_byte == KEY_LF) begin
                            n_cur = '0;
                            n_len = '0;
                            if (r_len != '0) begin
                                n_cnt   = r_len;
                                n_state = S_EMIT;
                            end else begin
                                n_kind = KIND_EMPTY;
                            end
                        end else if (i_key_byte == KEY_CANC) begin
                            n_cur  = '0;
                            n_len  = '0;
                            n_kind = KIND_CANCEL;
                        end else if (i_key_byte == KEY_DEL) begin
                            if (r_len == '0) begin
                                n_kind = KIND_EOF;
                            end else if (r_cur < r_len) begin
                                n_p     = r_cur + CW'(1);
                                n_erase = 1'b1;
                                n_state = S_FWD;
                            end
                        end else if (i_key_byte == KEY_RUB || i_key_byte == KEY_BS) begin
                            if (r_cur != '0) begin
                                n_p     = r_cur - CW'(1);
                                n_erase = 1'b1;
                                n_state = S_BWD;
                            end
                        end else if (i_key_byte == KEY_HOME) begin
                            n_cur = '0;
                        end else if (i_key_byte == KEY_END) begin
                            n_cur = r_len;
                        end else if (i_key_byte == KEY_KEND) begin
                            n_len = r_cur;
                        end else if (i_key_byte == KEY_KSTA) begin
                            if (r_cur != '0) begin
                                n_from  = '0;
                                n_cnt   = r_cur;
                                n_len   = r_len - r_cur;
                                n_cur   = '0;
                                n_state = S_ERASE;
                            end
                        end else if (i_key_byte == KEY_KWORD) begin
                            n_p     = r_cur;
                            n_state = S_WSP;
                        end else if (i_key_byte == KEY_ESC) begin
                            n_esc = E_FIRST;
                        end else if (i_key_byte >= KEY_SPACE) begin
                            if (r_len >= CAP) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_ctl.mode = CM_INS;
                                n_len = r_len + CW'(1);
                                n_cur = r_cur + CW'(1);
                            end
                        end else begin
                            n_ovf = 1'b0;
                        end
                    end
                end
            end
            // forward walk over continuation bytes
            S_FWD: begin
                if (r_p < r_len && w_cont[w_pi]) begin
                    n_p = r_p + CW'(1);
                end else if (r_erase) begin
                    n_from  = r_cur;
                    n_cnt   = r_p - r_cur;
                    n_len   = r_len - (r_p - r_cur);
                    n_state = S_ERASE;
                end else begin
                    n_cur   = r_p;
                    n_state = S_OUT;
                end
            end
            // backward walk to the character start
            S_BWD: begin
                if (r_p != '0 && w_cont[w_pi]) begin
                    n_p = w_pm1;
                end else if (r_erase) begin
                    n_from  = r_p;
                    n_cnt   = r_cur - r_p;
                    n_len   = r_len - (r_cur - r_p);
                    n_cur   = r_p;
                    n_state = S_ERASE;
                end else begin
                    n_cur   = r_p;
                    n_state = S_OUT;
                end
            end
            // skip spaces before the word
            S_WSP: begin
                if (r_p != '0 && w_space[w_pmi]) n_p = w_pm1;
                else n_state = S_WWD;
            end
            // skip the word itself
            S_WWD: begin
                if (r_p != '0 && !w_space[w_pmi]) begin
                    n_p = w_pm1;
                end else if (r_p < r_cur) begin
                    n_from  = r_p;
                    n_cnt   = r_cur - r_p;
                    n_len   = r_len - (r_cur - r_p);
                    n_cur   = r_p;
                    n_state = S_ERASE;
                end else begin
                    n_state = S_OUT;
                end
            end
            // close the gap one place per cycle
            S_ERASE: begin
                w_ctl.mode = CM_SHL;
                w_ctl.pos  = r_from;
                n_cnt      = r_cnt - CW'(1);
                if (r_cnt <= CW'(1)) n_state = S_OUT;
            end
            // send the line from cell zero, shifting the row down
            S_EMIT: begin
                if (w_free) begin
                    w_ctl.mode = CM_SHL;
                    w_ctl.pos  = '0;
                    w_load     = 1'b1;
                    w_lkind    = KIND_LINE;
                    w_lbyte    = w_data[0];
                    w_llast    = r_cnt == CW'(1);
                    w_lovf     = 1'b0;
                    n_cnt      = r_cnt - CW'(1);
                    if (r_cnt <= CW'(1)) n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_esc   <= E_IDLE;
            r_cur   <= '0;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_esc   <= n_esc;
            r_cur   <= n_cur;
            r_len   <= n_len;
            if (w_load) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    // work registers and output payload
    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_cnt   <= n_cnt;
        r_from  <= n_from;
        r_erase <= n_erase;
        r_kind  <= n_kind;
        r_ovf   <= n_ovf;
        if (w_load) begin
            r_okind <= w_lkind;
            r_obyte <= w_lbyte;
            r_ocur  <= n_cur;
            r_olen  <= n_len;
            r_oovf  <= w_lovf;
            r_olast <= w_llast;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_kind       = r_okind;
    assign o_line_byte  = r_obyte;
    assign o_cursor_now = r_ocur;
    assign o_length_now = r_olen;
    assign o_overflow   = r_oovf;
    assign o_last       = r_olast;

    // checks
    `ULNED_ASSERT_ALWAYS(a_cur_in_line, i_clk, i_rst_n, r_cur <= r_len && r_len <= CAP)
    `ULNED_ASSERT_IMPL(a_erase_nonzero, i_clk, i_rst_n, r_state == S_ERASE, r_cnt != '0)
    `ULNED_ASSERT_NEXT(a_emit_last, i_clk, i_rst_n,
        r_state == S_EMIT && w_free && r_cnt == CW'(1), r_state == S_IDLE && o_last)
endmodule
`default_nettype wire
